[src/silu_pkg.sv]
package silu_pkg;

    localparam int ROW_MAX_DEF     = 1024;
    localparam int STORE_DEPTH_DEF = 4096;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int OP_W        = 3;
    localparam int ADDR_W      = 12;
    localparam int IDX_W       = 13;
    localparam int DATA_W      = 32;
    localparam int ROW_COUNT_W = 11;

    typedef enum logic [OP_W-1:0] {
        OP_WR_INDEX = 3'd0,
        OP_WR_VALUE = 3'd1,
        OP_WR_RHS   = 3'd2,
        OP_SOLVE    = 3'd3,
        OP_READ     = 3'd4
    } op_t;

    localparam logic KIND_SOLVE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [ADDR_W-1:0]        address;
        logic [IDX_W-1:0]         index_entry;
        logic signed [DATA_W-1:0] number;
    } req_t;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] solution;
        logic                     saturated;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_F_START,
        ST_F_LO,
        ST_F_HI,
        ST_F_CHK,
        ST_F_COL,
        ST_F_MUL,
        ST_F_ACC,
        ST_F_WR,
        ST_B_START,
        ST_B_LO,
        ST_B_HI,
        ST_B_CHK,
        ST_B_COL,
        ST_B_MUL,
        ST_B_ACC,
        ST_B_DIAG,
        ST_B_DMUL,
        ST_B_DACC,
        ST_DONE
    } state_t;

    // saturating a - b, flag on clip
    function automatic logic [DATA_W:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] d;
        logic [DATA_W:0] r;
        d = (DATA_W+1)'(a) - (DATA_W+1)'(b);
        if (d[DATA_W] != d[DATA_W-1]) begin
            r = d[DATA_W] ? {1'b1, 1'b1, {(DATA_W-1){1'b0}}}
                          : {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = {1'b0, d[DATA_W-1:0]};
        end
        return r;
    endfunction

endpackage

[src/silu_ram.sv]
module silu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[src/silu_qmul.sv]
module silu_qmul #(
    parameter int FRAC_BITS = silu_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic signed [silu_pkg::DATA_W-1:0] a,
    input  logic signed [silu_pkg::DATA_W-1:0] b,
    output logic signed [silu_pkg::DATA_W-1:0] q,
    output logic                               ovf
);
    import silu_pkg::*;

    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [2*DATA_W-1:0] shifted;
    logic [DATA_W:0]            top_bits;

    always_ff @(posedge aclk) begin
        prod_reg <= (2*DATA_W)'(a) * (2*DATA_W)'(b);
    end

    // arithmetic shift is the floor
    assign shifted  = prod_reg >>> FRAC_BITS;
    assign top_bits = shifted[2*DATA_W-1:DATA_W-1];

    always_comb begin
        ovf = !((top_bits == '0) || (top_bits == '1));
        if (!ovf) begin
            q = shifted[DATA_W-1:0];
        end else if (shifted[2*DATA_W-1]) begin
            q = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            q = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end
endmodule

[src/silu_engine.sv]
module silu_engine #(
    parameter int ROW_MAX     = silu_pkg::ROW_MAX_DEF,
    parameter int STORE_DEPTH = silu_pkg::STORE_DEPTH_DEF,
    parameter int FRAC_BITS   = silu_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [$clog2(ROW_MAX+1)-1:0]   n,
    input  silu_pkg::req_t                 req,
    input  logic                           req_valid,
    output logic                           req_ready,
    output silu_pkg::res_t                 res,
    output logic                           res_valid,
    input  logic                           res_ready
);
    import silu_pkg::*;

    localparam int AW_S = $clog2(STORE_DEPTH);
    localparam int AW_R = $clog2(ROW_MAX);
    localparam int RW   = $clog2(ROW_MAX+1);

    state_t state_reg, state_next;

    logic [RW-1:0]            row_reg, row_next;
    logic [IDX_W-1:0]         ptr_reg, ptr_next;
    logic [IDX_W-1:0]         end_reg, end_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] sol_out_reg, sol_out_next;
    logic                     ovf_reg, ovf_next;
    logic                     kind_reg, kind_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;

    logic                     accept;
    logic                     row_in_store, next_in_store;
    logic                     fwd_more, fwd_stop, bwd_stop;
    logic [IDX_W-1:0]         k_raw;

    // memory ports
    logic                     idx_we, val_we, rhs_we, work_we, sol_we;
    logic [AW_S-1:0]          idx_raddr, val_raddr;
    logic [AW_R-1:0]          rhs_raddr, work_raddr, sol_raddr;
    logic [IDX_W-1:0]         idx_rd;
    logic [DATA_W-1:0]        val_rd, rhs_rd, work_rd, sol_rd;
    logic signed [DATA_W-1:0] mul_a, mul_b, mul_q;
    logic                     mul_ovf;
    logic [DATA_W:0]          sub_r;

    assign accept        = req_valid && req_ready;
    assign row_in_store  = 32'(row_reg) < 32'(STORE_DEPTH);
    assign next_in_store = (32'(row_reg) + 32'd1) < 32'(STORE_DEPTH);
    assign fwd_more      = (ptr_reg < end_reg) && (32'(ptr_reg) < 32'(STORE_DEPTH));
    assign fwd_stop      = 32'(idx_rd) >= 32'(row_reg);
    assign bwd_stop      = (32'(idx_rd) <= 32'(row_reg)) || (32'(idx_rd) >= 32'(n));
    assign k_raw         = next_in_store ? idx_rd : '0;
    assign sub_r         = sat_sub(acc_reg, mul_q);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (op_t'(req.operation))
                        OP_SOLVE: state_next = ST_F_START;
                        OP_READ:  state_next = ST_RD_WAIT;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_WAIT: state_next = ST_DONE;
            ST_F_START: state_next = ST_F_LO;
            ST_F_LO:    state_next = ST_F_HI;
            ST_F_HI:    state_next = ST_F_CHK;
            ST_F_CHK:   state_next = fwd_more ? ST_F_COL : ST_F_WR;
            ST_F_COL:   state_next = fwd_stop ? ST_F_WR : ST_F_MUL;
            ST_F_MUL:   state_next = ST_F_ACC;
            ST_F_ACC:   state_next = ST_F_CHK;
            ST_F_WR:    state_next = (32'(row_reg) + 32'd1 == 32'(n)) ? ST_B_START
                                                                     : ST_F_START;
            ST_B_START: state_next = ST_B_LO;
            ST_B_LO:    state_next = ST_B_HI;
            ST_B_HI:    state_next = ST_B_CHK;
            ST_B_CHK:   state_next = (ptr_reg > end_reg) ? ST_B_COL : ST_B_DIAG;
            ST_B_COL:   state_next = bwd_stop ? ST_B_DIAG : ST_B_MUL;
            ST_B_MUL:   state_next = ST_B_ACC;
            ST_B_ACC:   state_next = ST_B_CHK;
            ST_B_DIAG:  state_next = ST_B_DMUL;
            ST_B_DMUL:  state_next = ST_B_DACC;
            ST_B_DACC:  state_next = (row_reg == '0) ? ST_DONE : ST_B_START;
            ST_DONE:    state_next = res_ready ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        row_next     = row_reg;
        ptr_next     = ptr_reg;
        end_next     = end_reg;
        acc_next     = acc_reg;
        val_next     = val_reg;
        sol_out_next = sol_out_reg;
        ovf_next     = ovf_reg;
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        idx_we       = 1'b0;
        val_we       = 1'b0;
        rhs_we       = 1'b0;
        work_we      = 1'b0;
        sol_we       = 1'b0;
        idx_raddr    = AW_S'(row_reg);
        val_raddr    = AW_S'(ptr_reg - 1'b1);
        rhs_raddr    = AW_R'(row_reg);
        work_raddr   = AW_R'(idx_rd);
        sol_raddr    = AW_R'(idx_rd);
        mul_a        = '0;
        mul_b        = '0;
        req_ready    = 1'b0;
        res_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                sol_raddr = AW_R'(req.address);
                if (accept) begin
                    addr_next = req.address;
                    case (op_t'(req.operation))
                        OP_WR_INDEX: idx_we = 32'(req.address) < 32'(STORE_DEPTH);
                        OP_WR_VALUE: val_we = 32'(req.address) < 32'(STORE_DEPTH);
                        OP_WR_RHS:   rhs_we = 32'(req.address) < 32'(ROW_MAX);
                        OP_SOLVE: begin
                            row_next  = '0;
                            ovf_next  = 1'b0;
                            kind_next = KIND_SOLVE;
                        end
                        OP_READ:     kind_next = KIND_READ;
                        default: ;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                sol_out_next = (32'(addr_reg) < 32'(ROW_MAX)) ? sol_rd : '0;
            end
            ST_F_START: begin
                idx_raddr = AW_S'(row_reg);
            end
            ST_F_LO: begin
                ptr_next  = row_in_store ? idx_rd : '0;
                acc_next  = rhs_rd;
                idx_raddr = AW_S'(32'(row_reg) + 32'd1);
            end
            ST_F_HI: begin
                end_next = k_raw;
            end
            ST_F_CHK: begin
                idx_raddr = AW_S'(ptr_reg);
                val_raddr = AW_S'(ptr_reg);
            end
            ST_F_COL: begin
                val_next   = val_rd;
                work_raddr = AW_R'(idx_rd);
            end
            ST_F_MUL: begin
                mul_a = val_reg;
                mul_b = work_rd;
            end
            ST_F_ACC: begin
                acc_next = sub_r[DATA_W-1:0];
                ovf_next = ovf_reg | mul_ovf | sub_r[DATA_W];
                ptr_next = ptr_reg + 1'b1;
            end
            ST_F_WR: begin
                work_we = 1'b1;
                if (32'(row_reg) + 32'd1 != 32'(n)) begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_B_START: begin
                idx_raddr  = AW_S'(row_reg);
                work_raddr = AW_R'(row_reg);
            end
            ST_B_LO: begin
                acc_next  = work_rd;
                end_next  = row_in_store ? idx_rd : '0;
                idx_raddr = AW_S'(32'(row_reg) + 32'd1);
            end
            ST_B_HI: begin
                ptr_next = (32'(k_raw) > 32'(STORE_DEPTH)) ? IDX_W'(STORE_DEPTH) : k_raw;
            end
            ST_B_CHK: begin
                idx_raddr = AW_S'(ptr_reg - 1'b1);
                val_raddr = AW_S'(ptr_reg - 1'b1);
            end
            ST_B_COL: begin
                val_next  = val_rd;
                sol_raddr = AW_R'(idx_rd);
            end
            ST_B_MUL: begin
                mul_a = val_reg;
                mul_b = sol_rd;
            end
            ST_B_ACC: begin
                acc_next = sub_r[DATA_W-1:0];
                ovf_next = ovf_reg | mul_ovf | sub_r[DATA_W];
                ptr_next = ptr_reg - 1'b1;
            end
            ST_B_DIAG: begin
                val_raddr = AW_S'(row_reg);
            end
            ST_B_DMUL: begin
                mul_a = acc_reg;
                mul_b = row_in_store ? val_rd : '0;
            end
            ST_B_DACC: begin
                sol_we   = 1'b1;
                ovf_next = ovf_reg | mul_ovf;
                if (row_reg != '0) begin
                    row_next = row_reg - 1'b1;
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
        end
        row_reg     <= row_next;
        ptr_reg     <= ptr_next;
        end_reg     <= end_next;
        acc_reg     <= acc_next;
        val_reg     <= val_next;
        sol_out_reg <= sol_out_next;
        kind_reg    <= kind_next;
        addr_reg    <= addr_next;
    end

    assign res.kind      = kind_reg;
    assign res.solution  = (kind_reg == KIND_READ) ? sol_out_reg : '0;
    assign res.saturated = ovf_reg;

    silu_ram #(.WIDTH(IDX_W), .DEPTH(STORE_DEPTH)) u_idx_ram (
        .aclk(aclk), .we(idx_we), .waddr(AW_S'(req.address)), .wdata(req.index_entry),
        .raddr(idx_raddr), .rdata(idx_rd)
    );

    silu_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_val_ram (
        .aclk(aclk), .we(val_we), .waddr(AW_S'(req.address)), .wdata(req.number),
        .raddr(val_raddr), .rdata(val_rd)
    );

    silu_ram #(.WIDTH(DATA_W), .DEPTH(ROW_MAX)) u_rhs_ram (
        .aclk(aclk), .we(rhs_we), .waddr(AW_R'(req.address)), .wdata(req.number),
        .raddr(rhs_raddr), .rdata(rhs_rd)
    );

    silu_ram #(.WIDTH(DATA_W), .DEPTH(ROW_MAX)) u_work_ram (
        .aclk(aclk), .we(work_we), .waddr(AW_R'(row_reg)), .wdata(acc_reg),
        .raddr(work_raddr), .rdata(work_rd)
    );

    silu_ram #(.WIDTH(DATA_W), .DEPTH(ROW_MAX)) u_sol_ram (
        .aclk(aclk), .we(sol_we), .waddr(AW_R'(row_reg)), .wdata(mul_q),
        .raddr(sol_raddr), .rdata(sol_rd)
    );

    silu_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
        .aclk(aclk), .a(mul_a), .b(mul_b), .q(mul_q), .ovf(mul_ovf)
    );
endmodule

[src/sparse_ilu_triangular_solve_top.sv]
// Incomplete-LU triangular solve, z = (LU)^-1 r, signed Q16.16.
// Input channel s_*: one request per valid/ready handshake. Operations load
// the index store, the value store and the right-hand side, start a solve
// or read one solution element. Result channel m_*: a solve returns one
// result with kind 0 and the sticky saturation flag; a read returns kind 1
// and the element. Writes return nothing.
// Writes are taken back to back while the engine idles. A read's result
// passes the RD_WAIT and DONE states and the output register. A solve's
// result is offered once the forward and then the backward sweep are done;
// each sweep walks every row and its stored off-diagonals one at a time,
// as set by the one-read-per-cycle store ports and the shared multiplier.
// The user writes row_count through cfg_wr_en/cfg_wr_data while the block
// idles; the block does not enforce this. Zero acts as one row, values
// above ROW_MAX as ROW_MAX. Reset clears the control and the flag and sets
// row_count to 1; the stores keep their contents and hold nothing defined
// until written. A result waits in the output register while m_ready is
// low; the engine takes requests until a solve or read result stalls it.
module sparse_ilu_triangular_solve_top #(
    parameter int ROW_MAX     = silu_pkg::ROW_MAX_DEF,
    parameter int STORE_DEPTH = silu_pkg::STORE_DEPTH_DEF,
    parameter int FRAC_BITS   = silu_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [silu_pkg::ROW_COUNT_W-1:0]     cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [silu_pkg::OP_W-1:0]            s_operation,
    input  logic [silu_pkg::ADDR_W-1:0]          s_address,
    input  logic [silu_pkg::IDX_W-1:0]           s_index_entry,
    input  logic signed [silu_pkg::DATA_W-1:0]   s_number,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_kind,
    output logic signed [silu_pkg::DATA_W-1:0]   m_solution,
    output logic                                 m_saturated
);
    import silu_pkg::*;

    localparam int RW = $clog2(ROW_MAX+1);

    logic [ROW_COUNT_W-1:0] row_count_reg;
    logic [RW-1:0]          n_eff;
    req_t                   req;
    res_t                   res, res_reg;
    logic                   res_valid, res_ready;
    logic                   m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= ROW_COUNT_W'(1);
        end else if (cfg_wr_en) begin
            row_count_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (row_count_reg == '0) begin
            n_eff = RW'(1);
        end else if (32'(row_count_reg) > 32'(ROW_MAX)) begin
            n_eff = RW'(ROW_MAX);
        end else begin
            n_eff = RW'(row_count_reg);
        end
    end

    assign req.operation   = s_operation;
    assign req.address     = s_address;
    assign req.index_entry = s_index_entry;
    assign req.number      = s_number;

    silu_engine #(
        .ROW_MAX(ROW_MAX), .STORE_DEPTH(STORE_DEPTH), .FRAC_BITS(FRAC_BITS)
    ) u_engine (
        .aclk(aclk), .aresetn(aresetn), .n(n_eff),
        .req(req), .req_valid(s_valid), .req_ready(s_ready),
        .res(res), .res_valid(res_valid), .res_ready(res_ready)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = res_reg.kind;
    assign m_solution  = res_reg.solution;
    assign m_saturated = res_reg.saturated;

    a_res_held: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid)
        else $error("engine dropped a pending result");

    a_solve_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_SOLVE) |-> (m_solution == '0))
        else $error("solve result carries nonzero solution");

    a_n_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_eff != '0) && (32'(n_eff) <= 32'(ROW_MAX)))
        else $error("effective row count out of range");
endmodule

[sim/tb_sparse_ilu_triangular_solve_top.sv]
module tb_sparse_ilu_triangular_solve_top;
    import silu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS       = ROW_MAX_DEF;
    localparam int DEPTH      = STORE_DEPTH_DEF;
    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int STALL_MAX  = 20000;
    localparam int LONG_HOLD  = 300;
    localparam int ITEM_GOAL  = 1350;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [ROW_COUNT_W-1:0]  cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [OP_W-1:0]         s_operation = '0;
    logic [ADDR_W-1:0]       s_address = '0;
    logic [IDX_W-1:0]        s_index_entry = '0;
    logic signed [DATA_W-1:0] s_number = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_kind;
    logic signed [DATA_W-1:0] m_solution;
    logic                    m_saturated;

    sparse_ilu_triangular_solve_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_address     (s_address),
        .s_index_entry (s_index_entry),
        .s_number      (s_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_solution    (m_solution),
        .m_saturated   (m_saturated)
    );

    always #1 aclk = ~aclk;

    // shadow copy of the factor, right-hand side and solution
    logic [IDX_W-1:0]       ptr_mem [DEPTH];
    int                     coef_mem [DEPTH];
    int                     rhs_mem [ROWS];
    int                     fwd_mem [ROWS];
    int                     sol_mem [ROWS];
    bit                     clip_flag = 1'b0;
    logic [ROW_COUNT_W-1:0] row_cnt = 11'd1;

    res_t pending_results [$];
    int   errors = 0;
    int   tally = 0;
    bit   tally_on = 1'b0;
    bit   quiet = 1'b0;
    bit   hold_req = 1'b0;

    typedef struct {
        logic [OP_W-1:0] op;
        int              addr;
        int              ient;
        int              num;
        bit              typed;
        res_t            want;
    } dir_row_t;

    dir_row_t dir_tab [$];

    function automatic int rows_used();
        if (row_cnt == 0) return 1;
        if (row_cnt > ROWS) return ROWS;
        return int'(row_cnt);
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) begin
            clip_flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clip_flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // floored Q16.16 product
    function automatic longint qprod(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip32(p >>> FRAC);
    endfunction

    function automatic int ptr_rd(input int p);
        return p < DEPTH ? int'(ptr_mem[p]) : 0;
    endfunction

    function automatic void ilu_apply();
        int n, i, j, hi, col, r, lo, k;
        longint acc;
        n = rows_used();
        clip_flag = 1'b0;
        for (i = 0; i < n; i++) begin
            acc = rhs_mem[i];
            j = ptr_rd(i);
            hi = ptr_rd(i + 1);
            while (j < hi && j < DEPTH) begin
                col = int'(ptr_mem[j]);
                if (col >= i) break;
                acc = clip32(acc - qprod(coef_mem[j], fwd_mem[col]));
                j++;
            end
            fwd_mem[i] = int'(acc);
        end
        for (i = n; i > 0; i--) begin
            r = i - 1;
            acc = fwd_mem[r];
            lo = ptr_rd(r);
            k = ptr_rd(r + 1);
            if (k > DEPTH) k = DEPTH;
            while (k > lo) begin
                col = int'(ptr_mem[k - 1]);
                if (col <= r || col >= n) break;
                acc = clip32(acc - qprod(coef_mem[k - 1], sol_mem[col]));
                k--;
            end
            sol_mem[r] = int'(qprod(acc, r < DEPTH ? coef_mem[r] : 0));
        end
    endfunction

    function automatic bit predict(input logic [OP_W-1:0] op, input int addr, input int ient,
                                   input int num, output res_t r);
        r = '0;
        case (op)
            OP_WR_INDEX: ptr_mem[addr] = ient[IDX_W-1:0];
            OP_WR_VALUE: coef_mem[addr] = num;
            OP_WR_RHS: if (addr < ROWS) rhs_mem[addr] = num;
            OP_SOLVE: begin
                ilu_apply();
                r.kind = KIND_SOLVE;
                r.saturated = clip_flag;
                return 1'b1;
            end
            OP_READ: begin
                r.kind = KIND_READ;
                r.solution = addr < ROWS ? sol_mem[addr] : 0;
                r.saturated = clip_flag;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic send(input logic [OP_W-1:0] op, input int addr, input int ient,
                        input int num, input bit typed = 1'b0, input res_t want = '0);
        res_t r;
        bit has;
        s_valid = 1'b1;
        s_operation = op;
        s_address = addr[ADDR_W-1:0];
        s_index_entry = ient[IDX_W-1:0];
        s_number = num;
        do @(posedge aclk); while (!s_ready);
        has = predict(op, addr, ient, num, r);
        if (has) pending_results.push_back(typed ? want : r);
        if (tally_on && op <= OP_READ && !(op == OP_WR_RHS && addr >= ROWS)) tally++;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        // a trailing write may still be in flight
        repeat (10) @(negedge aclk);
    endtask

    task automatic set_rows(input int v);
        drain();
        cfg_wr_en = 1'b1;
        cfg_wr_data = v[ROW_COUNT_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        row_cnt = v[ROW_COUNT_W-1:0];
    endtask

    function automatic int rand_q();
        if ($urandom_range(0, 5) == 0) return int'($urandom);
        return int'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endfunction

    function automatic int rand_ient();
        return int'($urandom_range(0, 8191));
    endfunction

    // write a fresh well-formed factor and rhs for n rows
    task automatic load_factor(input int n);
        int p, i, c;
        bit tail;
        tail = n <= 16 && $urandom_range(0, 5) == 0;
        p = n + 1;
        for (i = 0; i < n; i++) begin
            send(OP_WR_VALUE, i, rand_ient(), rand_q());
            send(OP_WR_RHS, i, rand_ient(), rand_q());
            if (tail && i == n - 1) begin
                // last row sits at the very end of the store
                send(OP_WR_INDEX, i, DEPTH - 1, rand_q());
                send(OP_WR_INDEX, DEPTH - 1, $urandom_range(n - 1, DEPTH), rand_q());
                send(OP_WR_VALUE, DEPTH - 1, rand_ient(), rand_q());
            end else begin
                send(OP_WR_INDEX, i, p, rand_q());
                if (n <= 16) begin
                    for (c = 0; c < n; c++) begin
                        if (c != i && $urandom_range(0, 2) == 0) begin
                            send(OP_WR_INDEX, p, c, rand_q());
                            send(OP_WR_VALUE, p, rand_ient(), rand_q());
                            p++;
                        end
                    end
                    if ($urandom_range(0, 7) == 0) begin
                        // column past the active rows
                        send(OP_WR_INDEX, p, $urandom_range(n, DEPTH), rand_q());
                        send(OP_WR_VALUE, p, rand_ient(), rand_q());
                        p++;
                    end
                end
            end
        end
        send(OP_WR_INDEX, n, tail ? DEPTH : p, rand_q());
    endtask

    task automatic solve_and_read(input bit long_hold);
        int n, k, row;
        n = rows_used();
        load_factor(n);
        if (long_hold) hold_req = 1'b1;
        send(OP_SOLVE, $urandom_range(0, 4095), rand_ient(), rand_q());
        for (k = $urandom_range(1, 4); k > 0; k--) begin
            row = $urandom_range(0, 4) == 0 ? $urandom_range(ROWS, 4095)
                                            : $urandom_range(0, n - 1);
            send(OP_READ, row, rand_ient(), rand_q());
        end
        for (k = $urandom_range(0, 3); k > 0; k--) begin
            case ($urandom_range(0, 3))
                0: send(OP_WR_INDEX, $urandom_range(0, 4095), rand_ient(), rand_q());
                1: send(OP_WR_VALUE, $urandom_range(0, 4095), rand_ient(), int'($urandom));
                2: send(OP_WR_RHS, $urandom_range(0, 4095), rand_ient(), int'($urandom));
                default: send(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                              $urandom_range(0, 4095), rand_ient(), int'($urandom));
            endcase
        end
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input int addr, input int ient,
                           input int num, input bit typed = 1'b0, input logic kind = 1'b0,
                           input int sol = 0, input logic sat = 1'b0);
        dir_row_t d;
        d.op = op;
        d.addr = addr;
        d.ient = ient;
        d.num = num;
        d.typed = typed;
        d.want = '{kind: kind, solution: sol, saturated: sat};
        dir_tab.push_back(d);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        res_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, kind", m_kind, -1);
            end else begin
                w = pending_results.pop_front();
                if (m_kind !== w.kind) report_mismatch("kind", m_kind, w.kind);
                if (m_solution !== w.solution) report_mismatch("solution", m_solution, w.solution);
                if (m_saturated !== w.saturated)
                    report_mismatch("saturated", m_saturated, w.saturated);
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        int idle_left, hold_left;
        idle_left = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (quiet) begin
                m_ready = 1'b1;
            end else if (idle_left > 0) begin
                m_ready = 1'b0;
                idle_left--;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 10);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall = 0;
            else stall++;
            if (stall >= STALL_MAX) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int seq;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset row count is one
        add_row(OP_WR_INDEX, 0, 2, 0);
        add_row(OP_WR_INDEX, 1, 2, 0);
        add_row(OP_WR_VALUE, 0, 0, 32'h0001_0000);
        add_row(OP_WR_RHS, 0, 0, 32'h0005_0000);
        add_row(OP_SOLVE, 0, 0, 0, 1'b1, KIND_SOLVE, 0, 1'b0);
        add_row(OP_READ, 0, 0, 0, 1'b1, KIND_READ, 32'h0005_0000, 1'b0);
        add_row(OP_READ, 4095, 8191, -1, 1'b1, KIND_READ, 0, 1'b0);
        add_row(OP_WR_RHS, ROWS, 0, 32'h0000_1234);
        add_row(OP_SPARE_FIRST, 4095, 8191, -1);
        add_row(OP_SPARE_FIRST + 3'd1, 0, 0, 0);
        add_row(OP_SPARE_LAST, 1234, 4096, 32'h5555_aaaa);
        add_row(OP_READ, 0, 0, 0, 1'b1, KIND_READ, 32'h0005_0000, 1'b0);
        add_row(OP_WR_RHS, 0, 0, 32'h7fff_ffff);
        add_row(OP_WR_VALUE, 0, 0, 32'h7fff_ffff);
        add_row(OP_SOLVE, 0, 0, 0, 1'b1, KIND_SOLVE, 0, 1'b1);
        add_row(OP_READ, 0, 0, 0, 1'b1, KIND_READ, 32'h7fff_ffff, 1'b1);
        add_row(OP_WR_RHS, 0, 0, 32'h8000_0000);
        add_row(OP_SOLVE, 0, 0, 0, 1'b1, KIND_SOLVE, 0, 1'b1);
        add_row(OP_READ, 0, 0, 0, 1'b1, KIND_READ, 32'h8000_0000, 1'b1);
        add_row(OP_WR_RHS, 0, 0, 32'h0001_2345);
        add_row(OP_WR_VALUE, 0, 0, 32'hfffe_0000);
        add_row(OP_SOLVE, 0, 0, 0);
        add_row(OP_READ, 0, 0, 0);
        add_row(OP_WR_INDEX, 4095, 4096, 0);
        foreach (dir_tab[i])
            send(dir_tab[i].op, dir_tab[i].addr, dir_tab[i].ient, dir_tab[i].num,
                 dir_tab[i].typed, dir_tab[i].want);

        tally_on = 1'b1;
        seq = 0;
        while (tally < ITEM_GOAL) begin
            if (seq == 8) begin
                set_rows(0);
            end else if (seq % 4 == 0) begin
                set_rows($urandom_range(1, 8));
            end
            if (tally > ITEM_GOAL - 200) quiet = 1'b1;
            if (seq == 12) drain();
            solve_and_read(seq == 5);
            seq++;
        end

        drain();
        repeat (20) @(negedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
src/silu_pkg.sv
src/silu_ram.sv
src/silu_qmul.sv
src/silu_engine.sv
src/sparse_ilu_triangular_solve_top.sv
sim/tb_sparse_ilu_triangular_solve_top.sv
